// ===== src/pink_noise_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Pink noise generator assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef PINK_NOISE_GENERATOR_DEFINES_SVH
`define PINK_NOISE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define PNK_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define PNK_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pnk_pkg.sv =====
// ----------------------------------------------------------------------------
// pnk_pkg
// Shared types, sizes and constants of the pink noise generator.
// ----------------------------------------------------------------------------
package pnk_pkg;

  // Generator geometry
  localparam int NUM_ROWS    = 20;
  localparam int RANDOM_BITS = 24;

  // Field widths
  localparam int GAIN_W   = 16;
  localparam int SAMPLE_W = 24;
  localparam int SEED_W   = 32;
  localparam int LCG_W    = 32;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  // Register map
  localparam logic ADDR_STORED_AMP = 1'b0;
  localparam logic ADDR_SEED       = 1'b1;
  localparam logic [GAIN_W-1:0] STORED_AMP_RESET = 16'd16384;
  localparam logic [SEED_W-1:0] SEED_RESET       = 32'd0;

  // LCG
  localparam logic [LCG_W-1:0] LCG_MUL = 32'd196314165;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd907633515;

  // Row storage and sums
  localparam int TZ_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int SUM_W   = RANDOM_BITS + $clog2(NUM_ROWS);
  localparam int TOTAL_W = SUM_W + 1;

  // Shared multiplier
  localparam int MUL_W  = (TOTAL_W > 33) ? TOTAL_W : 33;
  localparam int PROD_W = 2 * MUL_W;

  // Scaling: total * g * 2^(24-RANDOM_BITS) / 2^14, then / (NUM_ROWS+1)
  localparam int SCALE_L = (RANDOM_BITS < 10) ? (10 - RANDOM_BITS) : 0;
  localparam int SCALE_R = (RANDOM_BITS > 10) ? (RANDOM_BITS - 10) : 0;
  localparam int DIVISOR = NUM_ROWS + 1;
  localparam longint SAT_SPAN = longint'(DIVISOR) * (longint'(1) << (SAMPLE_W - 1));
  localparam int U_W = $clog2(2 * SAT_SPAN);
  localparam int RECIP_SHIFT = 32;
  localparam longint RECIP = (longint'(1) << RECIP_SHIFT) / DIVISOR;
  localparam int Q_W = SAMPLE_W + 1;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 24'h7FFFFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 24'h800000;

  // Command queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Channel beats
  typedef struct packed {
    logic              restart;
    logic              use_stored_amp;
    logic [GAIN_W-1:0] gain;
  } pnk_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       clipped;
  } pnk_out_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic              restart;
    logic [GAIN_W-1:0] gain;
  } pnk_cmd_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROW,
    BK_WMUL,
    BK_WHITE,
    BK_SMUL,
    BK_SAT,
    BK_RMUL,
    BK_FIX
  } pnk_back_state_t;

  // Row picked by an index: its count of trailing zeros, capped at the top row
  function automatic logic [TZ_W-1:0] trailing_zeros(input logic [NUM_ROWS-1:0] n);
    logic [TZ_W-1:0] tz;
    tz = TZ_W'(NUM_ROWS - 1);
    for (int i = NUM_ROWS - 1; i >= 0; i--) begin
      if (n[i]) begin
        tz = TZ_W'(i);
      end
    end
    return tz;
  endfunction

endpackage

// ===== src/pink_noise_generator.sv =====
// ----------------------------------------------------------------------------
// pink_noise_generator
// Voss-McCartney pink noise source in fixed point, one sample per sample request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): each beat is a request. A
//   restart beat clears the 20 rows, the running sum and the row index and
//   reloads the LCG from the seed register; it gives no result. Any other
//   beat gives exactly one output beat (sample, clipped) scaled by its own
//   gain or by stored_amp.
//   The back end takes one command at a time. A sample runs through the
//   states IDLE, ROW (skipped when the row index wraps), WMUL, WHITE, SMUL,
//   SAT, RMUL and FIX; a restart is done in IDLE. The shared multiplier is
//   used for the row random value, the white value, the gain and the 1/21
//   reciprocal.
//   A 2-entry command queue lets requests be taken while the back end works
//   or while a finished sample waits in the output register.
//   Reset: stored_amp = 1.0 (Q2.14), seed = 0, LCG = 0, rows, sum, index 0.
//   Receiver stall: out_data holds; the back end waits with the next sample
//   and the queue fills, after which in_stall rises.
//   Registers over APB: stored_amp at 0x0, seed at 0x4; pready is always high.
// ----------------------------------------------------------------------------
module pink_noise_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pnk_pkg::pnk_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pnk_pkg::pnk_out_t            out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pnk_pkg::ADDR_W-1:0]   paddr,
  input  logic [pnk_pkg::DATA_W-1:0]   pwdata,
  output logic [pnk_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic                       q_push;
  logic                       q_full;
  logic                       q_pop;
  logic                       q_empty;
  pnk_pkg::pnk_cmd_t          q_in;
  pnk_pkg::pnk_cmd_t          q_out;
  logic [pnk_pkg::SEED_W-1:0] seed;

  pnk_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in),
    .seed     (seed)
  );

  pnk_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  pnk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .seed      (seed),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== src/pnk_fifo.sv =====
// ----------------------------------------------------------------------------
// pnk_fifo
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module pnk_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pnk_pkg::pnk_cmd_t push_data,
  output logic              full,
  input  logic              pop,
  output pnk_pkg::pnk_cmd_t pop_data,
  output logic              empty
);

  pnk_pkg::pnk_cmd_t                 entries [pnk_pkg::QUEUE_DEPTH];
  logic [pnk_pkg::QPTR_W-1:0]        wr_ptr;
  logic [pnk_pkg::QPTR_W-1:0]        rd_ptr;
  logic [pnk_pkg::QCNT_W-1:0]        count;
  logic                              do_push;
  logic                              do_pop;

  assign full     = (count == pnk_pkg::QCNT_W'(pnk_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == pnk_pkg::QPTR_W'(pnk_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == pnk_pkg::QPTR_W'(pnk_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/pnk_front.sv =====
// ----------------------------------------------------------------------------
// pnk_front
// Register file and input side: takes request beats, resolves the gain and
// queues a command for the back end.
// ----------------------------------------------------------------------------
module pnk_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  pnk_pkg::pnk_in_t             in_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pnk_pkg::ADDR_W-1:0]   paddr,
  input  logic [pnk_pkg::DATA_W-1:0]   pwdata,
  output logic [pnk_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         q_full,
  output logic                         q_push,
  output pnk_pkg::pnk_cmd_t            q_data,
  output logic [pnk_pkg::SEED_W-1:0]   seed
);

  logic [pnk_pkg::GAIN_W-1:0] stored_amp;
  logic                       cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  // Write configuration; only paddr[2] selects the register, low address bits are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_amp <= pnk_pkg::STORED_AMP_RESET;
      seed       <= pnk_pkg::SEED_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        pnk_pkg::ADDR_STORED_AMP: stored_amp <= pwdata[pnk_pkg::GAIN_W-1:0];
        pnk_pkg::ADDR_SEED:       seed       <= pwdata[pnk_pkg::SEED_W-1:0];
        default:                  seed       <= seed;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (paddr[2])
      pnk_pkg::ADDR_STORED_AMP: prdata = pnk_pkg::DATA_W'(stored_amp);
      pnk_pkg::ADDR_SEED:       prdata = pnk_pkg::DATA_W'(seed);
      default:                  prdata = '0;
    endcase
  end

  // Classify the beat and pick its gain
  assign in_stall       = q_full;
  assign q_push         = in_valid && !q_full;
  assign q_data.restart = in_data.restart;
  assign q_data.gain    = in_data.use_stored_amp ? stored_amp : in_data.gain;

endmodule

// ===== src/pnk_mul.sv =====
// ----------------------------------------------------------------------------
// pnk_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pnk_mul (
  input  logic                               clk,
  input  logic signed [pnk_pkg::MUL_W-1:0]   a,
  input  logic signed [pnk_pkg::MUL_W-1:0]   b,
  output logic signed [pnk_pkg::PROD_W-1:0]  prod
);

  // Register the full product
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// ===== src/pnk_back.sv =====
// ----------------------------------------------------------------------------
// pnk_back
// Generator back end: LCG, row bank, running sum, scaling by gain and by
// 1/(rows+1) with saturation, and the output register.
// ----------------------------------------------------------------------------
module pnk_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  input  pnk_pkg::pnk_cmd_t            q_data,
  output logic                         q_pop,
  input  logic [pnk_pkg::SEED_W-1:0]   seed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output pnk_pkg::pnk_out_t            out_data
);

  pnk_pkg::pnk_back_state_t state;
  pnk_pkg::pnk_back_state_t state_next;

  // Generator state
  logic [pnk_pkg::LCG_W-1:0]                   lcg;
  logic [pnk_pkg::NUM_ROWS-1:0]                row_index;
  logic signed [pnk_pkg::RANDOM_BITS-1:0]      rows [pnk_pkg::NUM_ROWS];
  logic signed [pnk_pkg::SUM_W-1:0]            sum;

  // Per-sample working registers
  logic [pnk_pkg::TZ_W-1:0]                    tz;
  logic [pnk_pkg::GAIN_W-1:0]                  gain_q;
  logic signed [pnk_pkg::TOTAL_W-1:0]          total;
  logic                                        clip_q;
  logic [pnk_pkg::SAMPLE_W-1:0]                sat_q;
  logic [pnk_pkg::U_W-1:0]                     u_q;

  // Datapath
  logic signed [pnk_pkg::MUL_W-1:0]            mul_a;
  logic signed [pnk_pkg::MUL_W-1:0]            mul_b;
  logic signed [pnk_pkg::PROD_W-1:0]           prod;
  logic [pnk_pkg::NUM_ROWS-1:0]                idx_inc;
  logic [pnk_pkg::LCG_W-1:0]                   lcg_new;
  logic signed [pnk_pkg::RANDOM_BITS-1:0]      rnd;
  logic signed [pnk_pkg::PROD_W-1:0]           scaled;
  logic                                        over_hi;
  logic                                        over_lo;
  logic [pnk_pkg::Q_W-1:0]                     q0;
  logic [pnk_pkg::U_W-1:0]                     q0_times_div;
  logic [pnk_pkg::U_W-1:0]                     rem;
  logic [pnk_pkg::Q_W-1:0]                     quot;
  logic [pnk_pkg::SAMPLE_W-1:0]                fix_sample;
  logic                                        out_free;

  pnk_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign out_free = !out_valid || !out_stall;
  assign idx_inc  = row_index + 1'b1;

  // New LCG value and its signed top bits
  assign lcg_new = prod[pnk_pkg::LCG_W-1:0] + pnk_pkg::LCG_ADD;
  assign rnd     = lcg_new[pnk_pkg::LCG_W-1 -: pnk_pkg::RANDOM_BITS];

  // Scale by 2^(24-RANDOM_BITS)/2^14 with floor, then range check
  assign scaled  = (prod <<< pnk_pkg::SCALE_L) >>> pnk_pkg::SCALE_R;
  assign over_hi = scaled >= pnk_pkg::PROD_W'(pnk_pkg::SAT_SPAN);
  assign over_lo = scaled < pnk_pkg::PROD_W'(-pnk_pkg::SAT_SPAN);

  // Quotient by reciprocal, then one correction step
  assign q0           = prod[pnk_pkg::RECIP_SHIFT +: pnk_pkg::Q_W];
  assign q0_times_div = pnk_pkg::U_W'(q0) * pnk_pkg::U_W'(pnk_pkg::DIVISOR);
  assign rem          = u_q - q0_times_div;
  assign quot         = (rem >= pnk_pkg::U_W'(pnk_pkg::DIVISOR)) ? q0 + 1'b1 : q0;
  // Remove the offset of the biased dividend
  assign fix_sample   = {~quot[pnk_pkg::SAMPLE_W-1], quot[pnk_pkg::SAMPLE_W-2:0]};

  // Sequence one command
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      pnk_pkg::BK_IDLE: begin
        mul_a = pnk_pkg::MUL_W'(lcg);
        mul_b = pnk_pkg::MUL_W'(pnk_pkg::LCG_MUL);
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_data.restart) begin
            state_next = pnk_pkg::BK_IDLE;
          end else if (idx_inc != '0) begin
            state_next = pnk_pkg::BK_ROW;
          end else begin
            state_next = pnk_pkg::BK_WMUL;
          end
        end
      end
      pnk_pkg::BK_ROW: begin
        state_next = pnk_pkg::BK_WMUL;
      end
      pnk_pkg::BK_WMUL: begin
        mul_a      = pnk_pkg::MUL_W'(lcg);
        mul_b      = pnk_pkg::MUL_W'(pnk_pkg::LCG_MUL);
        state_next = pnk_pkg::BK_WHITE;
      end
      pnk_pkg::BK_WHITE: begin
        state_next = pnk_pkg::BK_SMUL;
      end
      pnk_pkg::BK_SMUL: begin
        mul_a      = pnk_pkg::MUL_W'(total);
        mul_b      = pnk_pkg::MUL_W'(gain_q);
        state_next = pnk_pkg::BK_SAT;
      end
      pnk_pkg::BK_SAT: begin
        state_next = pnk_pkg::BK_RMUL;
      end
      pnk_pkg::BK_RMUL: begin
        mul_a      = pnk_pkg::MUL_W'(u_q);
        mul_b      = pnk_pkg::MUL_W'(pnk_pkg::RECIP);
        state_next = pnk_pkg::BK_FIX;
      end
      pnk_pkg::BK_FIX: begin
        // Hold the reciprocal product while the result side stalls
        mul_a = pnk_pkg::MUL_W'(u_q);
        mul_b = pnk_pkg::MUL_W'(pnk_pkg::RECIP);
        if (out_free) begin
          state_next = pnk_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = pnk_pkg::BK_IDLE;
      end
    endcase
  end

  // Hold state, generator and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pnk_pkg::BK_IDLE;
      lcg       <= pnk_pkg::SEED_RESET;
      row_index <= '0;
      sum       <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < pnk_pkg::NUM_ROWS; i++) begin
        rows[i] <= '0;
      end
    end else begin
      state <= state_next;
      case (state)
        pnk_pkg::BK_IDLE: begin
          if (!q_empty) begin
            if (q_data.restart) begin
              lcg       <= seed;
              row_index <= '0;
              sum       <= '0;
              for (int i = 0; i < pnk_pkg::NUM_ROWS; i++) begin
                rows[i] <= '0;
              end
            end else begin
              row_index <= idx_inc;
            end
          end
        end
        pnk_pkg::BK_ROW: begin
          lcg      <= lcg_new;
          rows[tz] <= rnd;
          sum      <= sum + pnk_pkg::SUM_W'(rnd) - pnk_pkg::SUM_W'(rows[tz]);
        end
        pnk_pkg::BK_WHITE: begin
          lcg <= lcg_new;
        end
        default: begin
          lcg <= lcg;
        end
      endcase
      // Load a finished sample, drop a taken one
      if (state == pnk_pkg::BK_FIX && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (state)
      pnk_pkg::BK_IDLE: begin
        tz     <= pnk_pkg::trailing_zeros(idx_inc);
        gain_q <= q_data.gain;
      end
      pnk_pkg::BK_WHITE: begin
        total <= pnk_pkg::TOTAL_W'(sum) + pnk_pkg::TOTAL_W'(rnd);
      end
      pnk_pkg::BK_SAT: begin
        clip_q <= over_hi || over_lo;
        sat_q  <= over_hi ? pnk_pkg::SAMPLE_MAX : pnk_pkg::SAMPLE_MIN;
        u_q    <= pnk_pkg::U_W'(scaled + pnk_pkg::PROD_W'(pnk_pkg::SAT_SPAN));
      end
      pnk_pkg::BK_FIX: begin
        if (out_free) begin
          out_data.sample  <= clip_q ? sat_q : fix_sample;
          out_data.clipped <= clip_q;
        end
      end
      default: begin
        tz <= tz;
      end
    endcase
  end

endmodule

// ===== src/pnk_checker.sv =====
// ----------------------------------------------------------------------------
// pnk_checker
// Port-level checks on the pink noise generator, bound to the top level.
// ----------------------------------------------------------------------------
`include "pink_noise_generator_defines.svh"

module pnk_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_stall,
  input pnk_pkg::pnk_out_t            out_data,
  input logic                         psel,
  input logic                         pwrite,
  input logic [pnk_pkg::ADDR_W-1:0]   paddr,
  input logic [pnk_pkg::DATA_W-1:0]   prdata
);

  // Hold a stalled result beat
  `PNK_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out beat dropped while stalled")
  `PNK_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data), "out beat changed while stalled")

  // A clipped sample sits at a range limit
  `PNK_ASSERT_SAME(a_clip_limit, out_valid && out_data.clipped, out_data.sample == pnk_pkg::SAMPLE_MAX || out_data.sample == pnk_pkg::SAMPLE_MIN, "clipped sample not at a limit")

  // The amplitude register reads back with clear upper bits
  `PNK_ASSERT_SAME(a_amp_read, psel && !pwrite && paddr[2] == pnk_pkg::ADDR_STORED_AMP, prdata[pnk_pkg::DATA_W-1:pnk_pkg::GAIN_W] == '0, "stored_amp read has upper bits set")

endmodule

bind pink_noise_generator pnk_checker u_checker (.*);

// ===== bench/tb_pink_noise_generator.sv =====
// ----------------------------------------------------------------------------
// tb_pink_noise_generator
// Self-checking bench for the pink noise generator. A table of hand-picked
// requests runs first, then phases of random requests under different
// stored_amp and seed settings. A local copy of the row/LCG generator
// predicts every sample, and each output beat is checked against it in
// order. Both channels idle and stall at random, except in the last phase.
// ----------------------------------------------------------------------------
module tb_pink_noise_generator;

  // Generator geometry and arithmetic, kept apart from the package
  localparam int          ROW_COUNT     = 20;
  localparam int          DRAW_BITS     = 24;
  localparam logic [31:0] LCG_FACTOR    = 32'd196314165;
  localparam logic [31:0] LCG_OFFSET    = 32'd907633515;
  localparam longint      SCALE_DEN     = longint'(ROW_COUNT + 1) << 14;
  localparam longint      SAMPLE_TOP    = 64'sd8388607;
  localparam longint      SAMPLE_BOTTOM = -64'sd8388608;

  // Register map
  localparam int          AMP_INDEX  = 0;
  localparam int          SEED_INDEX = 1;
  localparam logic [15:0] AMP_RESET  = 16'd16384;
  localparam logic [31:0] SEED_RESET = 32'd0;

  // Run shape
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int DRAIN_CYCLES    = 30;
  localparam int NUM_DIRECTED    = 16;

  // Directed request with an optional hand-typed result
  typedef struct packed {
    logic        restart;
    logic        use_amp;
    logic [15:0] gain;
    logic        pinned;
    logic [23:0] want_sample;
    logic        want_clip;
  } stim_row_t;

  // Hand-typed result that travels with the request beat
  typedef struct packed {
    logic              on;
    pnk_pkg::pnk_out_t res;
  } pin_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  pnk_pkg::pnk_in_t    in_data;
  logic                out_valid;
  logic                out_stall;
  pnk_pkg::pnk_out_t   out_data;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  pin_t                cur_pin;
  bit                  quiet = 1'b0;
  bit                  idle_on = 1'b1;
  int                  error_count = 0;
  pnk_pkg::pnk_out_t   expected_samples[$];

  // Local generator state and register copies
  logic [31:0]         lcg_q;
  logic [19:0]         row_idx_q;
  longint              rows_q[ROW_COUNT];
  longint              sum_q;
  logic [15:0]         amp_q;
  logic [31:0]         seed_q;

  // Extremes, restart mixes and plain unity-gain requests
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    '{1'b0, 1'b0, 16'h0000, 1'b1, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'hFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b1, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h4000, 1'b0, 24'h000000, 1'b0},
    '{1'b1, 1'b0, 16'hFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h0000, 1'b1, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'hFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b1, 1'b1, 16'hFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b1, 16'hFFFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h8000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h0001, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h7FFF, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'hAAAA, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h5555, 1'b0, 24'h000000, 1'b0},
    '{1'b1, 1'b0, 16'h0000, 1'b0, 24'h000000, 1'b0},
    '{1'b0, 1'b0, 16'h0000, 1'b1, 24'h000000, 1'b0}
  };

  pink_noise_generator i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // Clear rows, sum and index; reload the LCG from the seed copy
  function automatic void clear_generator();
    foreach (rows_q[i]) rows_q[i] = 0;
    sum_q = 0;
    row_idx_q = '0;
    lcg_q = seed_q;
  endfunction

  // Step the LCG and return its signed top bits
  function automatic longint draw_random();
    logic [DRAW_BITS-1:0] top;
    lcg_q = lcg_q * LCG_FACTOR + LCG_OFFSET;
    top = lcg_q[31 -: DRAW_BITS];
    return longint'($signed(top));
  endfunction

  // Advance the generator by one request; return 1 when it yields a sample
  function automatic bit advance_generator(input pnk_pkg::pnk_in_t req,
                                           output pnk_pkg::pnk_out_t res);
    logic [15:0] g;
    int          tz;
    longint      fresh;
    longint      total;
    longint      num;
    longint      q;
    res = '0;
    if (req.restart) begin
      clear_generator();
      return 1'b0;
    end
    g = req.use_stored_amp ? amp_q : req.gain;
    row_idx_q = row_idx_q + 1'b1;
    // Refresh the row picked by the index's trailing zeros
    if (row_idx_q != '0) begin
      tz = 0;
      while (!row_idx_q[tz] && tz < ROW_COUNT - 1) tz++;
      fresh = draw_random();
      sum_q += fresh - rows_q[tz];
      rows_q[tz] = fresh;
    end
    total = sum_q + draw_random();
    // Scale by gain/(21*2^14), rounding toward minus infinity
    num = total * longint'(g);
    if (num >= 0) begin
      q = num / SCALE_DEN;
    end else begin
      q = -((-num + SCALE_DEN - 1) / SCALE_DEN);
    end
    if (q > SAMPLE_TOP) begin
      q = SAMPLE_TOP;
      res.clipped = 1'b1;
    end else if (q < SAMPLE_BOTTOM) begin
      q = SAMPLE_BOTTOM;
      res.clipped = 1'b1;
    end
    res.sample = q[23:0];
    return 1'b1;
  endfunction

  function automatic pnk_pkg::pnk_in_t random_request(input bit allow_restart);
    pnk_pkg::pnk_in_t r;
    r.restart = allow_restart && ($urandom_range(0, 24) == 0);
    r.use_stored_amp = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: begin
        r.gain = 16'h0000;
      end
      1: begin
        r.gain = 16'hFFFF;
      end
      2: begin
        r.gain = 16'h4000;
      end
      default: begin
        r.gain = 16'($urandom);
      end
    endcase
    return r;
  endfunction

  // Predict on every accepted request beat
  always @(posedge clk) begin : accept_side
    pnk_pkg::pnk_out_t res;
    if (!rst && in_valid && !in_stall) begin
      if (advance_generator(in_data, res)) begin
        if (cur_pin.on) begin
          expected_samples.push_back(cur_pin.res);
        end else begin
          expected_samples.push_back(res);
        end
      end
    end
  end

  // Check every accepted sample beat against the oldest prediction
  always @(posedge clk) begin : result_side
    pnk_pkg::pnk_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_samples.size() == 0) begin
        $display("%0t: unexpected sample beat, actual sample %0d clipped %0b",
                 $time, out_data.sample, out_data.clipped);
        error_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data.sample !== want.sample) begin
          $display("%0t: sample mismatch, expected %0d actual %0d",
                   $time, want.sample, out_data.sample);
          error_count++;
        end
        if (out_data.clipped !== want.clipped) begin
          $display("%0t: clipped mismatch, expected %0b actual %0b",
                   $time, want.clipped, out_data.clipped);
          error_count++;
        end
      end
    end
  end

  // Stall the result side in short random bursts
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Send one request beat, with a random gap ahead of it
  task automatic send_request(input pnk_pkg::pnk_in_t req, input pin_t pin);
    if (!quiet && idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    cur_pin <= pin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and let every outstanding sample come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want,
                                input logic [31:0] mask);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) !== (want & mask)) begin
      $display("%0t: register 0x%0h readback, expected 0x%0h actual 0x%0h",
               $time, addr, want & mask, prdata & mask);
      error_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write a register, mirror it locally and read it back
  task automatic program_register(input int index, input logic [31:0] value);
    logic [2:0]  addr;
    logic [31:0] mask;
    addr = 3'(4 * index);
    mask = (index == AMP_INDEX) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    apb_write(addr, value);
    if (index == AMP_INDEX) begin
      amp_q = value[15:0];
    end else begin
      seed_q = value;
    end
    apb_read_check(addr, value, mask);
  endtask

  // Main sequence
  initial begin
    logic [15:0]      amp_plan [PHASES];
    logic [31:0]      seed_plan [PHASES];
    pnk_pkg::pnk_in_t req;
    pin_t             pin;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cur_pin = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    amp_q = AMP_RESET;
    seed_q = SEED_RESET;
    clear_generator();
    amp_plan = '{16'h0000, 16'hFFFF, 16'h4000, 16'h0000, 16'h0000, 16'hFFFF};
    seed_plan = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0};
    amp_plan[3] = 16'($urandom);
    amp_plan[4] = 16'($urandom);
    seed_plan[3] = $urandom;
    seed_plan[4] = $urandom;
    seed_plan[5] = $urandom;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers come up at their reset values
    apb_read_check(3'(4 * AMP_INDEX), 32'(AMP_RESET), 32'h0000_FFFF);
    apb_read_check(3'(4 * SEED_INDEX), SEED_RESET, 32'hFFFF_FFFF);

    // Walk the directed table
    foreach (directed_rows[i]) begin
      req.restart = directed_rows[i].restart;
      req.use_stored_amp = directed_rows[i].use_amp;
      req.gain = directed_rows[i].gain;
      pin.on = directed_rows[i].pinned;
      pin.res.sample = directed_rows[i].want_sample;
      pin.res.clipped = directed_rows[i].want_clip;
      send_request(req, pin);
    end
    wait_idle();

    // Random phases; a new seed only takes hold at the restart beat
    for (int p = 0; p < PHASES; p++) begin
      quiet = (p == PHASES - 1);
      program_register(AMP_INDEX, 32'(amp_plan[p]));
      program_register(SEED_INDEX, seed_plan[p]);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (k % 32 == 0) idle_on = ($urandom_range(0, 3) != 0);
        req = random_request(k > 3);
        if (k == 3) req.restart = 1'b1;
        send_request(req, '0);
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb_pink_noise_generator: PASS");
    end else begin
      $display("tb_pink_noise_generator: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3000000;
    $display("tb_pink_noise_generator: FAIL");
    $finish;
  end

endmodule
